FILE: src/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and constants of the Intel HEX record parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihex_pkg;

  localparam int unsigned AddrWidth = 17;
  localparam int unsigned BaseWidth = 16;

  localparam logic [7:0]           ColonChar   = 8'h3A;
  localparam logic [7:0]           ByteMask    = 8'hFF;
  localparam logic [AddrWidth-1:0] LowReset    = {AddrWidth{1'b1}};
  localparam logic [AddrWidth-1:0] HighReset   = '0;

  localparam logic ReqChar  = 1'b0;
  localparam logic ReqBegin = 1'b1;

  localparam logic KindData   = 1'b0;
  localparam logic KindRecord = 1'b1;

  localparam logic CfgIdxLow  = 1'b0;
  localparam logic CfgIdxHigh = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  typedef struct packed {
    logic                 kind;
    logic [AddrWidth-1:0] write_address;
    logic [7:0]           write_byte;
    logic                 checksum_bad;
    logic [BaseWidth-1:0] record_base;
    logic [AddrWidth-1:0] lowest_start;
    logic [AddrWidth-1:0] highest_end;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_digit_t;

endpackage

FILE: src/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Intel HEX text parser emitting data byte writes and record summaries.
// ----------------------------------------------------------------------------
// Takes one character or begin-file request per cycle unless the output
// stalls, fully pipelined: the item is captured in an input register,
// decoded by one pass of record logic and its result, if any, is written
// to the output register. The input side stalls only while the output
// register holds a result that the consumer has not taken. Register writes
// are always taken and apply at the next begin-file request.
`timescale 1ns / 1ps

module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [AddrWidth-1:0] cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [7:0]           char_byte_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 result_kind_o,
  output logic [AddrWidth-1:0] write_address_o,
  output logic [7:0]           write_byte_o,
  output logic                 checksum_bad_o,
  output logic [BaseWidth-1:0] record_base_o,
  output logic [AddrWidth-1:0] lowest_start_o,
  output logic [AddrWidth-1:0] highest_end_o
);

  logic [AddrWidth-1:0] init_low_q;
  logic [AddrWidth-1:0] init_high_q;

  logic       in_valid_q;
  logic       in_req_q;
  logic [7:0] in_char_q;

  logic       out_valid_q;
  result_t    out_q;

  logic       advance;
  logic       res_valid;
  result_t    res;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_low_q  <= LowReset;
      init_high_q <= HighReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgIdxLow:  init_low_q  <= cfg_data_i;
        CfgIdxHigh: init_high_q <= cfg_data_i;
        default:    init_low_q  <= init_low_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q  <= req_type_i;
      in_char_q <= char_byte_i;
    end
  end

  ihex_parse_core u_parse_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .req_type_i  (in_req_q),
    .char_byte_i (in_char_q),
    .init_low_i  (init_low_q),
    .init_high_i (init_high_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_q.kind;
  assign write_address_o = out_q.write_address;
  assign write_byte_o    = out_q.write_byte;
  assign checksum_bad_o  = out_q.checksum_bad;
  assign record_base_o   = out_q.record_base;
  assign lowest_start_o  = out_q.lowest_start;
  assign highest_end_o   = out_q.highest_end;

`ifndef SYNTHESIS
  a_data_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindData |->
      !checksum_bad_o && record_base_o == '0 && lowest_start_o == '0 && highest_end_o == '0)
    else $error("data transfer carries record summary fields");

  a_record_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindRecord |-> write_address_o == '0 && write_byte_o == '0)
    else $error("record transfer carries data write fields");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty output register");
`endif

endmodule

FILE: src/ihex_hex_decode.sv
// ----------------------------------------------------------------------------
// ihex_hex_decode
// Classifies one ASCII character as a hex digit and gives its value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihex_hex_decode
  import ihex_pkg::*;
(
  input  logic [7:0] char_i,
  output hex_digit_t digit_o
);

  always_comb begin
    digit_o = '0;
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      digit_o.is_hex = 1'b1;
      digit_o.nibble = 4'(char_i - 8'h30);
    end else if (char_i >= 8'h61 && char_i <= 8'h66) begin
      digit_o.is_hex = 1'b1;
      digit_o.nibble = 4'(char_i - 8'h57);
    end else if (char_i >= 8'h41 && char_i <= 8'h46) begin
      digit_o.is_hex = 1'b1;
      digit_o.nibble = 4'(char_i - 8'h37);
    end
  end

endmodule

FILE: src/ihex_parse_core.sv
// ----------------------------------------------------------------------------
// ihex_parse_core
// Record state machine: field assembly, checksum, address trackers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihex_parse_core
  import ihex_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 req_type_i,
  input  logic [7:0]           char_byte_i,
  input  logic [AddrWidth-1:0] init_low_i,
  input  logic [AddrWidth-1:0] init_high_i,
  output logic                 res_valid_o,
  output result_t              res_o
);

  phase_e               phase_q, phase_d;
  logic [1:0]           digit_count_q, digit_count_d;
  logic [15:0]          field_value_q, field_value_d;
  logic                 field_stopped_q, field_stopped_d;
  logic [7:0]           bytes_left_q, bytes_left_d;
  logic [BaseWidth-1:0] base_address_q, base_address_d;
  logic [AddrWidth-1:0] next_address_q, next_address_d;
  logic [7:0]           byte_sum_q, byte_sum_d;
  logic [AddrWidth-1:0] low_tracker_q, low_tracker_d;
  logic [AddrWidth-1:0] high_tracker_q, high_tracker_d;

  hex_digit_t  digit;
  logic [15:0] field_new;
  logic        stopped_new;
  logic        field_last;
  logic [7:0]  bytes_dec;
  logic [7:0]  sum_check;

  ihex_hex_decode u_hex_decode (
    .char_i  (char_byte_i),
    .digit_o (digit)
  );

  always_comb begin
    field_new   = field_value_q;
    stopped_new = field_stopped_q;
    if (!field_stopped_q) begin
      if (digit.is_hex) begin
        field_new = {field_value_q[11:0], digit.nibble};
      end else begin
        stopped_new = 1'b1;
      end
    end
    field_last = (phase_q == PH_ADDR) ? (digit_count_q == 2'd3) : (digit_count_q != 2'd0);
    bytes_dec  = bytes_left_q - 8'd1;
    sum_check  = byte_sum_q + field_new[7:0];
  end

  always_comb begin
    phase_d         = phase_q;
    digit_count_d   = digit_count_q;
    field_value_d   = field_value_q;
    field_stopped_d = field_stopped_q;
    bytes_left_d    = bytes_left_q;
    base_address_d  = base_address_q;
    next_address_d  = next_address_q;
    byte_sum_d      = byte_sum_q;
    low_tracker_d   = low_tracker_q;
    high_tracker_d  = high_tracker_q;

    if (req_type_i == ReqBegin) begin
      phase_d         = PH_HUNT;
      digit_count_d   = '0;
      field_value_d   = '0;
      field_stopped_d = 1'b0;
      bytes_left_d    = '0;
      base_address_d  = '0;
      next_address_d  = '0;
      byte_sum_d      = '0;
      low_tracker_d   = init_low_i;
      high_tracker_d  = init_high_i;
    end else begin
      case (phase_q)
        PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CHECK: begin
          if (!field_last) begin
            digit_count_d   = digit_count_q + 2'd1;
            field_value_d   = field_new;
            field_stopped_d = stopped_new;
          end else begin
            digit_count_d   = '0;
            field_value_d   = '0;
            field_stopped_d = 1'b0;
            case (phase_q)
              PH_LEN: begin
                bytes_left_d = field_new[7:0];
                byte_sum_d   = sum_check;
                phase_d      = PH_ADDR;
              end
              PH_ADDR: begin
                base_address_d = field_new;
                next_address_d = {1'b0, field_new};
                byte_sum_d     = byte_sum_q + field_new[15:8] + field_new[7:0];
                phase_d        = PH_TYPE;
              end
              PH_TYPE: begin
                byte_sum_d = sum_check;
                if (field_new[7:0] != 8'd0) begin
                  phase_d = PH_HUNT;
                end else if (bytes_left_q == 8'd0) begin
                  phase_d = PH_CHECK;
                end else begin
                  phase_d = PH_DATA;
                end
              end
              PH_DATA: begin
                next_address_d = next_address_q + AddrWidth'(1);
                byte_sum_d     = sum_check;
                bytes_left_d   = bytes_dec;
                if (bytes_dec == 8'd0) begin
                  phase_d = PH_CHECK;
                end
              end
              default: begin
                byte_sum_d = sum_check;
                if (low_tracker_q > {1'b0, base_address_q}) begin
                  low_tracker_d = {1'b0, base_address_q};
                end
                if (high_tracker_q < next_address_q) begin
                  high_tracker_d = next_address_q;
                end
                phase_d = PH_HUNT;
              end
            endcase
          end
        end
        default: begin
          if (char_byte_i == ColonChar) begin
            phase_d         = PH_LEN;
            digit_count_d   = '0;
            field_value_d   = '0;
            field_stopped_d = 1'b0;
            byte_sum_d      = '0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (req_type_i == ReqChar && field_last) begin
      case (phase_q)
        PH_DATA: begin
          res_valid_o         = 1'b1;
          res_o.kind          = KindData;
          res_o.write_address = next_address_q;
          res_o.write_byte    = field_new[7:0] & ByteMask;
        end
        PH_CHECK: begin
          res_valid_o        = 1'b1;
          res_o.kind         = KindRecord;
          res_o.checksum_bad = (sum_check != 8'd0);
          res_o.record_base  = base_address_q;
          res_o.lowest_start = low_tracker_d;
          res_o.highest_end  = high_tracker_d;
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HUNT;
      digit_count_q   <= '0;
      field_value_q   <= '0;
      field_stopped_q <= 1'b0;
      bytes_left_q    <= '0;
      base_address_q  <= '0;
      next_address_q  <= '0;
      byte_sum_q      <= '0;
      low_tracker_q   <= LowReset;
      high_tracker_q  <= HighReset;
    end else if (advance_i) begin
      phase_q         <= phase_d;
      digit_count_q   <= digit_count_d;
      field_value_q   <= field_value_d;
      field_stopped_q <= field_stopped_d;
      bytes_left_q    <= bytes_left_d;
      base_address_q  <= base_address_d;
      next_address_q  <= next_address_d;
      byte_sum_q      <= byte_sum_d;
      low_tracker_q   <= low_tracker_d;
      high_tracker_q  <= high_tracker_d;
    end
  end

`ifndef SYNTHESIS
  a_begin_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && req_type_i == ReqBegin |=> phase_q == PH_HUNT && byte_sum_q == 8'd0)
    else $error("begin-file did not return the parser to colon hunting");

  a_record_end_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_valid_o && res_o.kind == KindRecord |=> phase_q == PH_HUNT)
    else $error("parser left record end in a field phase");

  a_phase_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_CHECK)
    else $error("parser entered an unused phase code");
`endif

endmodule
